/* sv/circular_double_ended_queue_assert.svh */
// ----------------------------------------------------------------------------
// circular_double_ended_queue assertion macros
// Shorthand for clocked assertions on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define CIRCULAR_DOUBLE_ENDED_QUEUE_ASSERT_SVH

// same-cycle implication
`define CDQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CDQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/cdq_pkg.sv */
// ----------------------------------------------------------------------------
// cdq_pkg
// Types and codes shared by the deque and its channel interfaces.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int DEPTH  = 16;
  localparam int CAP_W  = 5;
  localparam int VAL_W  = 32;
  localparam int CMD_W  = 3;
  localparam int STAT_W = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic signed [VAL_W-1:0] push_value;
  } cdq_in_word_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] popped_value;
    logic signed [VAL_W-1:0] front_value;
    logic signed [VAL_W-1:0] back_value;
    logic                    is_empty;
    logic                    is_full;
  } cdq_out_word_t;

endpackage

/* sv/cdq_if.sv */
// ----------------------------------------------------------------------------
// cdq channel interfaces
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface cdq_in_if;
  import cdq_pkg::*;

  logic         valid;
  logic         ready;
  cdq_in_word_t word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

interface cdq_out_if;
  import cdq_pkg::*;

  logic          valid;
  logic          ready;
  cdq_out_word_t word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

/* sv/circular_double_ended_queue.sv */
// ----------------------------------------------------------------------------
// circular_double_ended_queue
// Double-ended queue over a ring of register slots with a run-time capacity.
// ----------------------------------------------------------------------------
// One command word is taken per cycle unless the result register is stalled,
// and one result word is produced for each; an accepted word passes through
// the command register, then the result register, which is loaded with one
// update of pointers, end-value registers and one slot. The values at both
// ends are held in registers, so each command reads at most one slot. The
// slots come up undefined and need no clearing pass. Capacity is clamped to
// 1..DEPTH and should be changed only while no command is in flight.
`include "circular_double_ended_queue_assert.svh"

module circular_double_ended_queue (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [cdq_pkg::CAP_W-1:0] cfg_wdata,
  cdq_in_if.sink                    in_s,
  cdq_out_if.source                 out_m
);
  import cdq_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = (IW + 1 > CAP_W) ? IW + 1 : CAP_W;

  typedef logic [IW-1:0] idx_t;
  typedef logic [CW-1:0] cnt_t;

  function automatic idx_t next_idx(idx_t p, cnt_t n);
    cnt_t pe;
    pe = cnt_t'(p) + cnt_t'(1);
    return (pe >= n) ? '0 : idx_t'(pe);
  endfunction

  function automatic idx_t prev_idx(idx_t p, cnt_t n);
    return (p == '0 || cnt_t'(p) >= n) ? idx_t'(n - cnt_t'(1)) : p - idx_t'(1);
  endfunction

  logic [CAP_W-1:0]        cap_r;
  idx_t                    front_r, front_nxt;
  idx_t                    back_r, back_nxt;
  logic                    empty_r, empty_nxt;
  logic signed [VAL_W-1:0] fval_r, fval_nxt;
  logic signed [VAL_W-1:0] bval_r, bval_nxt;
  logic signed [VAL_W-1:0] slot_r [DEPTH];
  logic                    in_vld_r;
  cdq_in_word_t            in_word_r;
  logic                    out_vld_r;
  cdq_out_word_t           out_word_r, out_word_nxt;

  cnt_t                    ring_sz;
  logic                    proc;
  logic                    full_now;
  idx_t                    rd_addr;
  logic signed [VAL_W-1:0] rd_val;
  logic                    wen;
  idx_t                    waddr;
  logic [STAT_W-1:0]       status;
  logic signed [VAL_W-1:0] popped;

  assign proc       = in_vld_r && (!out_vld_r || out_m.ready);
  assign in_s.ready = !in_vld_r || proc;
  assign out_m.valid = out_vld_r;
  assign out_m.word  = out_word_r;

  always_comb begin
    if (cap_r == '0) begin
      ring_sz = cnt_t'(1);
    end else if (cnt_t'(cap_r) > cnt_t'(DEPTH)) begin
      ring_sz = cnt_t'(DEPTH);
    end else begin
      ring_sz = cnt_t'(cap_r);
    end
  end

  assign full_now = !empty_r && (next_idx(back_r, ring_sz) == front_r);
  assign rd_addr  = (in_word_r.command == CMD_POP_FRONT) ? next_idx(front_r, ring_sz)
                                                         : prev_idx(back_r, ring_sz);
  assign rd_val   = slot_r[rd_addr];

  always_comb begin
    front_nxt = front_r;
    back_nxt  = back_r;
    empty_nxt = empty_r;
    fval_nxt  = fval_r;
    bval_nxt  = bval_r;
    wen       = 1'b0;
    waddr     = '0;
    status    = STAT_OK;
    popped    = '0;
    case (in_word_r.command) inside
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (empty_r) begin
          front_nxt = '0;
          back_nxt  = '0;
          empty_nxt = 1'b0;
          wen       = 1'b1;
          fval_nxt  = in_word_r.push_value;
          bval_nxt  = in_word_r.push_value;
        end else if (full_now) begin
          status = STAT_OVERFLOW;
        end else if (in_word_r.command == CMD_PUSH_FRONT) begin
          front_nxt = prev_idx(front_r, ring_sz);
          wen       = 1'b1;
          waddr     = front_nxt;
          fval_nxt  = in_word_r.push_value;
          if (waddr == back_r) begin
            bval_nxt = in_word_r.push_value;
          end
        end else begin
          back_nxt = next_idx(back_r, ring_sz);
          wen      = 1'b1;
          waddr    = back_nxt;
          bval_nxt = in_word_r.push_value;
          if (waddr == front_r) begin
            fval_nxt = in_word_r.push_value;
          end
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (empty_r) begin
          status = STAT_UNDERFLOW;
        end else begin
          popped = (in_word_r.command == CMD_POP_FRONT) ? fval_r : bval_r;
          if (front_r == back_r) begin
            front_nxt = '0;
            back_nxt  = '0;
            empty_nxt = 1'b1;
          end else if (in_word_r.command == CMD_POP_FRONT) begin
            front_nxt = rd_addr;
            fval_nxt  = rd_val;
          end else begin
            back_nxt = rd_addr;
            bval_nxt = rd_val;
          end
        end
      end
      default: begin
        if (empty_r) begin
          status = STAT_UNDERFLOW;
        end
      end
    endcase
  end

  always_comb begin
    out_word_nxt.status       = status;
    out_word_nxt.popped_value = popped;
    out_word_nxt.front_value  = empty_nxt ? '0 : fval_nxt;
    out_word_nxt.back_value   = empty_nxt ? '0 : bval_nxt;
    out_word_nxt.is_empty     = empty_nxt;
    out_word_nxt.is_full      = !empty_nxt && (next_idx(back_nxt, ring_sz) == front_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r     <= CAP_W'(DEPTH);
      front_r   <= '0;
      back_r    <= '0;
      empty_r   <= 1'b1;
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (in_s.ready) begin
        in_vld_r <= in_s.valid;
      end
      if (proc) begin
        out_vld_r <= 1'b1;
        front_r   <= front_nxt;
        back_r    <= back_nxt;
        empty_r   <= empty_nxt;
      end else if (out_m.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_s.valid && in_s.ready) begin
      in_word_r <= in_s.word;
    end
    if (proc) begin
      out_word_r <= out_word_nxt;
      fval_r     <= fval_nxt;
      bval_r     <= bval_nxt;
      if (wen) begin
        slot_r[waddr] <= in_word_r.push_value;
      end
    end
  end

  `CDQ_ASSERT_IMP(a_empty_ptrs, empty_r, front_r == '0 && back_r == '0,
                  "empty deque with pointers off zero")
  `CDQ_ASSERT_IMP(a_ovf_full, out_vld_r && out_word_r.status == STAT_OVERFLOW,
                  out_word_r.is_full && !out_word_r.is_empty, "overflow reported while not full")
  `CDQ_ASSERT_IMP(a_flags_excl, out_vld_r, !(out_word_r.is_empty && out_word_r.is_full),
                  "empty and full both set")
  `CDQ_ASSERT_NXT(a_cmd_hold, in_vld_r && !proc, in_vld_r && $stable(in_word_r),
                  "stalled command word lost")

endmodule

/* sim/tb_circular_double_ended_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circular_double_ended_queue
// Self-checking bench for the ring deque. Command words go in over a
// valid/ready channel, and each accepted word is run through a behavioral
// copy of the deque to build the expected result word. A checker compares
// every result word field by field, in order. Test phases cover the
// directed corner cases, a capacity sweep, resizing while entries are held,
// a long output stall, and random traffic under several idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_circular_double_ended_queue;
  import cdq_pkg::*;

  localparam int RING_SLOTS = DEPTH;
  localparam int DRAIN_CYCLES = 4;

  localparam logic [CMD_W-1:0] CMD_PEEK    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CAP_W-1:0]    cfg_wdata;

  cdq_in_if  in_ch ();
  cdq_out_if out_ch ();

  circular_double_ended_queue u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_s     (in_ch),
    .out_m    (out_ch)
  );

  // deque shadow state
  logic [VAL_W-1:0]      slot_mem [RING_SLOTS];
  logic [RING_SLOTS-1:0] slot_written;
  logic [3:0]            head_idx;
  logic [3:0]            tail_idx;
  logic                  deque_empty;
  logic [CAP_W-1:0]      cap_reg;

  cdq_out_word_t pending_results[$];
  int mismatch_count;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int ring_len();
    if (cap_reg == 0) return 1;
    if (cap_reg > RING_SLOTS) return RING_SLOTS;
    return int'(cap_reg);
  endfunction

  function automatic logic [3:0] ring_next(logic [3:0] p);
    return (int'(p) + 1 >= ring_len()) ? 4'd0 : p + 4'd1;
  endfunction

  function automatic logic [3:0] ring_prev(logic [3:0] p);
    return (p == 4'd0 || int'(p) >= ring_len()) ? 4'(ring_len() - 1) : p - 4'd1;
  endfunction

  function automatic bit deque_full();
    return !deque_empty && ring_next(tail_idx) == head_idx;
  endfunction

  function automatic cdq_out_word_t deque_step(cdq_in_word_t w);
    cdq_out_word_t r;
    r = '0;
    r.status = STAT_OK;
    case (w.command) inside
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (deque_empty) begin
          head_idx = 4'd0;
          tail_idx = 4'd0;
          deque_empty = 1'b0;
        end else if (deque_full()) begin
          r.status = STAT_OVERFLOW;
        end else if (w.command == CMD_PUSH_FRONT) begin
          head_idx = ring_prev(head_idx);
        end else begin
          tail_idx = ring_next(tail_idx);
        end
        if (r.status == STAT_OK) begin
          if (w.command == CMD_PUSH_FRONT) begin
            slot_mem[head_idx] = w.push_value;
            slot_written[head_idx] = 1'b1;
          end else begin
            slot_mem[tail_idx] = w.push_value;
            slot_written[tail_idx] = 1'b1;
          end
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (deque_empty) begin
          r.status = STAT_UNDERFLOW;
        end else begin
          r.popped_value = slot_mem[(w.command == CMD_POP_FRONT) ? head_idx : tail_idx];
          if (head_idx == tail_idx) begin
            head_idx = 4'd0;
            tail_idx = 4'd0;
            deque_empty = 1'b1;
          end else if (w.command == CMD_POP_FRONT) begin
            head_idx = ring_next(head_idx);
          end else begin
            tail_idx = ring_prev(tail_idx);
          end
        end
      end
      default: begin
        if (deque_empty) r.status = STAT_UNDERFLOW;
      end
    endcase
    if (!deque_empty) begin
      r.front_value = slot_mem[head_idx];
      r.back_value = slot_mem[tail_idx];
    end
    r.is_empty = deque_empty;
    r.is_full = deque_full();
    return r;
  endfunction

  function automatic void report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $realtime, what);
  endfunction

  function automatic logic [CMD_W-1:0] pick_command(bit filling);
    int r;
    r = $urandom_range(99);
    if (r < 8) return CMD_W'($urandom_range(7));
    if (r < 12) return CMD_PEEK;
    if ((r < 80) == filling) return $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
    return $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(15))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // entered and left at a falling edge
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] value);
    cdq_in_word_t w;
    w.command = cmd;
    w.push_value = value;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.word <= w;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_results.insert(pending_results.size(), deque_step(w));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic drain_deque();
    while (!deque_empty) send_cmd($urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK, $urandom);
  endtask

  // resizing while holding entries is only safe once every slot has been written
  task automatic set_capacity(input logic [CAP_W-1:0] value);
    if (!deque_empty && !(&slot_written)) drain_deque();
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    cap_reg = value;
  endtask

  task automatic run_traffic(input int count);
    bit filling;
    filling = 1'b1;
    repeat (count) begin
      if (deque_full()) filling = 1'b0;
      else if (deque_empty) filling = 1'b1;
      send_cmd(pick_command(filling), pick_value());
    end
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_cmd(CMD_POP_FRONT, 32'h1234_5678);
    send_cmd(CMD_POP_BACK, 32'h0);
    send_cmd(CMD_PEEK, 32'h0);
    send_cmd(CMD_SPARE_7, 32'h0);
    send_cmd(CMD_PUSH_FRONT, 32'h8000_0000);
    send_cmd(CMD_PUSH_BACK, 32'h7fff_ffff);
    send_cmd(CMD_PUSH_FRONT, 32'hffff_ffff);
    send_cmd(CMD_PEEK, 32'h0);
    send_cmd(CMD_SPARE_5, 32'h0);
    send_cmd(CMD_SPARE_6, 32'h0);
    send_cmd(CMD_POP_BACK, 32'h0);
    send_cmd(CMD_POP_FRONT, 32'h0);
    send_cmd(CMD_POP_FRONT, 32'h0);
    send_cmd(CMD_POP_BACK, 32'h0);
    // two-slot ring: wrap on push front, overflow both ways
    set_capacity(5'd2);
    send_cmd(CMD_PUSH_BACK, 32'h0000_0001);
    send_cmd(CMD_PUSH_FRONT, 32'h0000_0002);
    send_cmd(CMD_PUSH_BACK, 32'h0000_0003);
    send_cmd(CMD_PUSH_FRONT, 32'h0000_0004);
    send_cmd(CMD_POP_BACK, 32'h0);
    send_cmd(CMD_POP_BACK, 32'h0);
    // zero capacity behaves as one slot
    set_capacity(5'd0);
    send_cmd(CMD_PUSH_FRONT, 32'h5555_aaaa);
    send_cmd(CMD_PUSH_BACK, 32'haaaa_5555);
    send_cmd(CMD_POP_FRONT, 32'h0);
  endtask

  task automatic test_capacity_sweep();
    logic [CAP_W-1:0] caps [8];
    caps = '{5'd1, 5'd2, 5'd16, 5'd31, 5'd0, 5'd17, 5'd8, 5'd3};
    send_idle_pct = 0;
    recv_stall_pct = 0;
    foreach (caps[i]) begin
      set_capacity(caps[i]);
      run_traffic((caps[i] >= 5'd8) ? 30 : 12);
    end
  endtask

  task automatic test_live_resize();
    set_capacity(5'd16);
    drain_deque();
    repeat (RING_SLOTS) send_cmd(CMD_PUSH_BACK, pick_value());
    set_capacity(5'd5);
    run_traffic(15);
    set_capacity(5'd12);
    run_traffic(15);
    set_capacity(5'd31);
    run_traffic(10);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_capacity(5'd6);
    hold_cycles = 60;
    run_traffic(30);
    wait_drained();
  endtask

  task automatic test_random_mix();
    int idle_mix [4][2];
    idle_mix = '{'{0, 0}, '{77, 0}, '{0, 77}, '{6, 6}};
    foreach (idle_mix[i]) begin
      send_idle_pct = idle_mix[i][0];
      recv_stall_pct = idle_mix[i][1];
      repeat (2) begin
        set_capacity(CAP_W'($urandom_range(31)));
        run_traffic(16);
      end
    end
  endtask

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    cdq_out_word_t want;
    cdq_out_word_t got;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = out_ch.word;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result word with none expected: %h", got));
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (got.status !== want.status)
          report_mismatch($sformatf("status: expected %0d, got %0d", want.status, got.status));
        if (got.popped_value !== want.popped_value)
          report_mismatch($sformatf("popped_value: expected %h, got %h",
                                    want.popped_value, got.popped_value));
        if (got.front_value !== want.front_value)
          report_mismatch($sformatf("front_value: expected %h, got %h",
                                    want.front_value, got.front_value));
        if (got.back_value !== want.back_value)
          report_mismatch($sformatf("back_value: expected %h, got %h",
                                    want.back_value, got.back_value));
        if (got.is_empty !== want.is_empty)
          report_mismatch($sformatf("is_empty: expected %b, got %b", want.is_empty, got.is_empty));
        if (got.is_full !== want.is_full)
          report_mismatch($sformatf("is_full: expected %b, got %b", want.is_full, got.is_full));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.word = '0;
    out_ch.ready = 1'b0;
    mismatch_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    foreach (slot_mem[i]) slot_mem[i] = '0;
    slot_written = '0;
    head_idx = 4'd0;
    tail_idx = 4'd0;
    deque_empty = 1'b1;
    cap_reg = 5'd16;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_capacity_sweep();
    test_live_resize();
    test_backpressure();
    test_random_mix();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d result words never arrived", pending_results.size()));
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/cdq_pkg.sv
sv/cdq_if.sv
sv/circular_double_ended_queue.sv
sim/tb_circular_double_ended_queue.sv
